// File: sv/erd_pkg.sv
// ============================================================================
// erd_pkg
// Shared types and constants for the entry record deframer.
// ============================================================================
package erd_pkg;

    // Byte classification codes carried with every output word.
    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_PATH = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    // Input word as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } t_item;

    // One result word, ahead of packing onto the output stream.
    typedef struct packed {
        t_kind       byte_kind;
        logic [7:0]  out_byte;
        logic [15:0] body_len;
        logic [15:0] rec_type;
        logic [7:0]  name_len;
        logic        entry_done;
        logic        truncated;
    } t_result;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 3;

endpackage

// File: sv/erd_in_stage.sv
// ============================================================================
// erd_in_stage
// Input register: holds one accepted word until the parser consumes it.
// ============================================================================
module erd_in_stage
    import erd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // The register may take a new word when empty or when its word moves on.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/erd_parser.sv
// ============================================================================
// erd_parser
// Entry parser: tracks the header, path and data parts of each entry and
// classifies one byte per step.
// ============================================================================
module erd_parser
    import erd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_LEN_HI  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_TYPE_HI = 3'd2,
        PH_TYPE_LO = 3'd3,
        PH_PLEN    = 3'd4,
        PH_PATH    = 3'd5,
        PH_DATA    = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_type, n_type;
    logic [7:0]  r_plen, n_plen;
    logic [15:0] r_left, n_left;

    t_kind       kind;
    logic        done;
    logic        trunc;
    logic [7:0]  b;
    logic        left_end;

    assign b        = i_item.data_byte;
    assign left_end = (r_left <= 16'd1);

    // Next state and byte classification.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_plen  = r_plen;
        n_left  = r_left;
        kind    = KIND_HDR;
        done    = 1'b0;
        unique case (r_phase)
            PH_LEN_LO: begin
                n_len   = r_len | {8'd0, b};
                n_phase = PH_TYPE_HI;
            end
            PH_TYPE_HI: begin
                n_type  = {b, 8'd0};
                n_phase = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
                n_type  = r_type | {8'd0, b};
                n_phase = PH_PLEN;
            end
            PH_PLEN: begin
                n_plen = b;
                if (b != 8'd0) begin
                    n_left  = {8'd0, b};
                    n_phase = PH_PATH;
                end else if (r_len != 16'd0) begin
                    n_left  = r_len;
                    n_phase = PH_DATA;
                end else begin
                    done    = 1'b1;
                    n_phase = PH_LEN_HI;
                end
            end
            PH_PATH: begin
                kind = KIND_PATH;
                if (left_end) begin
                    if (r_len != 16'd0) begin
                        n_left  = r_len;
                        n_phase = PH_DATA;
                    end else begin
                        n_left  = 16'd0;
                        done    = 1'b1;
                        n_phase = PH_LEN_HI;
                    end
                end else begin
                    n_left = r_left - 16'd1;
                end
            end
            PH_DATA: begin
                kind = KIND_DATA;
                if (left_end) begin
                    n_left  = 16'd0;
                    done    = 1'b1;
                    n_phase = PH_LEN_HI;
                end else begin
                    n_left = r_left - 16'd1;
                end
            end
            default: begin
                // First header byte; the unused phase code lands here too.
                n_len   = {b, 8'd0};
                n_type  = 16'd0;
                n_plen  = 8'd0;
                n_left  = 16'd0;
                n_phase = PH_LEN_LO;
            end
        endcase
    end

    assign trunc = i_item.block_end && !done;

    // Result fields show the header values after this byte is taken in.
    always_comb begin
        o_result.byte_kind  = kind;
        o_result.out_byte   = b;
        o_result.body_len   = n_len;
        o_result.rec_type   = n_type;
        o_result.name_len   = n_plen;
        o_result.entry_done = done;
        o_result.truncated  = trunc;
    end

    // Parser state; a truncated block clears everything, a clean end restarts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_len   <= 16'd0;
            r_type  <= 16'd0;
            r_plen  <= 8'd0;
            r_left  <= 16'd0;
        end else if (i_step) begin
            if (trunc) begin
                r_phase <= PH_LEN_HI;
                r_len   <= 16'd0;
                r_type  <= 16'd0;
                r_plen  <= 8'd0;
                r_left  <= 16'd0;
            end else begin
                r_phase <= i_item.block_end ? PH_LEN_HI : n_phase;
                r_len   <= n_len;
                r_type  <= n_type;
                r_plen  <= n_plen;
                r_left  <= n_left;
            end
        end
    end

`ifndef SYNTH
    // A word never both completes an entry and reports truncation.
    a_done_not_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(done && trunc))
        else $error("entry_done and truncated set together");

    // After truncation the parser is back at a cleared header.
    a_trunc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && trunc) |=> (r_phase == PH_LEN_HI && r_len == 16'd0
                               && r_type == 16'd0 && r_plen == 8'd0))
        else $error("state not cleared after truncation");

    // Path and data parts always have bytes remaining.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PATH || r_phase == PH_DATA) |-> (r_left != 16'd0))
        else $error("empty remaining count in path or data part");

    // Header bytes are tagged as such exactly in the header phases.
    a_kind_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> ((kind == KIND_HDR) == (r_phase != PH_PATH && r_phase != PH_DATA)))
        else $error("byte kind disagrees with phase");
`endif

endmodule

// File: sv/erd_out_stage.sv
// ============================================================================
// erd_out_stage
// Result register: holds one finished word until the receiver takes it.
// ============================================================================
module erd_out_stage
    import erd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // A new word may load when the register is empty or is being drained.
    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// File: sv/entry_record_deframer.sv
// ============================================================================
// entry_record_deframer
// Splits a block of entry bytes into tagged header, path and data words.
// ============================================================================
// Usage: feed the payload bytes of a block on s_axis, one byte per word, with
// s_axis_tlast on the final byte of the block. Each entry is a big-endian
// 16-bit data length, a big-endian 16-bit content type, a path length byte,
// then the path bytes and the data bytes. Every input word yields exactly one
// word on m_axis: the byte itself, its kind (header, path, data), the header
// fields captured so far, m_axis_tlast on the last byte of each entry, and a
// truncation flag when the block ends inside an entry.
// An accepted byte is held in the input register, and the parser logic then
// loads its result into the result register, which drives m_axis_tvalid.
// Throughput is one byte per cycle while the receiver does not stall, with the
// parser step combinational between those two registers.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the first header byte. When the receiver stalls, the result
// register holds its word and the input register fills; s_axis_tready drops
// only once both are full, and no word is lost or repeated.
module entry_record_deframer
    import erd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic                   s_axis_tlast,  // block_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] out_byte, [23:8] entry_data_len, [39:24] entry_content_type,
    // [47:40] entry_path_len
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [1:0] byte_kind, [2] truncated
    output logic                   m_axis_tlast   // entry_done
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    step;
    t_result result;
    t_result out_result;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.block_end = s_axis_tlast;

    // Input register.
    erd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_ready (out_ready),
        .o_item  (held_item)
    );

    // The parser advances whenever the held word moves into the result register.
    assign step = held_valid && out_ready;

    erd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (result)
    );

    // Result register.
    erd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (out_ready),
        .i_result (result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // Pack the result word onto the output stream.
    assign m_axis_tdata = {out_result.name_len, out_result.rec_type,
                           out_result.body_len, out_result.out_byte};
    assign m_axis_tuser = {out_result.truncated, out_result.byte_kind};
    assign m_axis_tlast = out_result.entry_done;

endmodule

// File: test/erd_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// erd_checker
// Watches both streams of the entry record deframer and checks every word.
// ============================================================================
// Each byte taken in on the input stream is run through a parser of its own,
// and the tagged word it must produce is queued. Each word that leaves on the
// output stream is compared field by field with the oldest queued word. The
// failure count, the number of words still due and a few totals go to the
// top level.
module erd_checker
    import erd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic                   s_axis_tlast,  // block_end
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] out_byte, [23:8] entry_data_len, [39:24] entry_content_type,
    // [47:40] entry_path_len
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [1:0] byte_kind, [2] truncated
    input  logic                   m_axis_tlast,  // entry_done
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_words_checked,
    output int                     o_entries_done,
    output int                     o_truncations
);

    // Parser position codes: five header bytes, then the path and data parts.
    localparam logic [2:0] PH_LEN_HI   = 3'd0;
    localparam logic [2:0] PH_LEN_LO   = 3'd1;
    localparam logic [2:0] PH_TYPE_HI  = 3'd2;
    localparam logic [2:0] PH_TYPE_LO  = 3'd3;
    localparam logic [2:0] PH_PATH_LEN = 3'd4;
    localparam logic [2:0] PH_PATH     = 3'd5;
    localparam logic [2:0] PH_DATA     = 3'd6;

    logic [2:0]  parse_phase;
    logic [15:0] cur_body_len;
    logic [15:0] cur_rec_type;
    logic [7:0]  cur_name_len;
    logic [15:0] cur_left;

    t_result expected_words_q[$];
    int      fail_cnt;
    int      words_cnt;
    int      entries_cnt;
    int      trunc_cnt;

    // Returns the parser to the first header byte with all fields cleared.
    task automatic clear_parser();
        parse_phase  = PH_LEN_HI;
        cur_body_len = '0;
        cur_rec_type = '0;
        cur_name_len = '0;
        cur_left     = '0;
    endtask

    // Takes one entry byte into the parser and works out the word it yields.
    task automatic parse_entry_byte(input logic [7:0] b, input logic last,
                                    output t_result word);
        logic [2:0] ph;
        logic       done;
        logic       trunc;
        t_kind      kind;
        ph   = parse_phase;
        done = 1'b0;
        kind = KIND_HDR;
        if (ph > PH_DATA) begin
            ph = PH_LEN_HI;
        end
        case (ph)
            PH_LEN_HI: begin
                cur_body_len = {b, 8'h00};
                cur_rec_type = '0;
                cur_name_len = '0;
                cur_left     = '0;
                parse_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                cur_body_len = cur_body_len | {8'h00, b};
                parse_phase  = PH_TYPE_HI;
            end
            PH_TYPE_HI: begin
                cur_rec_type = {b, 8'h00};
                parse_phase  = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
                cur_rec_type = cur_rec_type | {8'h00, b};
                parse_phase  = PH_PATH_LEN;
            end
            PH_PATH_LEN: begin
                cur_name_len = b;
                if (b != 8'h00) begin
                    cur_left    = {8'h00, b};
                    parse_phase = PH_PATH;
                end else if (cur_body_len != 16'h0000) begin
                    cur_left    = cur_body_len;
                    parse_phase = PH_DATA;
                end else begin
                    // An entry with neither path nor data ends on its header.
                    done        = 1'b1;
                    parse_phase = PH_LEN_HI;
                end
            end
            PH_PATH: begin
                kind = KIND_PATH;
                if (cur_left <= 16'd1) begin
                    if (cur_body_len != 16'h0000) begin
                        cur_left    = cur_body_len;
                        parse_phase = PH_DATA;
                    end else begin
                        cur_left    = '0;
                        done        = 1'b1;
                        parse_phase = PH_LEN_HI;
                    end
                end else begin
                    cur_left = cur_left - 16'd1;
                end
            end
            default: begin
                kind = KIND_DATA;
                if (cur_left <= 16'd1) begin
                    cur_left    = '0;
                    done        = 1'b1;
                    parse_phase = PH_LEN_HI;
                end else begin
                    cur_left = cur_left - 16'd1;
                end
            end
        endcase

        trunc = last && !done;
        word.byte_kind  = kind;
        word.out_byte   = b;
        word.body_len   = cur_body_len;
        word.rec_type   = cur_rec_type;
        word.name_len   = cur_name_len;
        word.entry_done = done;
        word.truncated  = trunc;

        // A block that stops inside an entry throws the entry away.
        if (trunc) begin
            clear_parser();
        end else if (last) begin
            parse_phase = PH_LEN_HI;
        end
    endtask

    // Reports one field that differs from its expected value.
    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    // Compare outgoing words first, then queue the prediction for the byte
    // taken in at the same edge; a word never leaves in its own input cycle.
    always @(posedge i_clk) begin
        t_result exp_word;
        t_result new_word;
        if (!i_rst_n) begin
            clear_parser();
            expected_words_q.delete();
            fail_cnt    = 0;
            words_cnt   = 0;
            entries_cnt = 0;
            trunc_cnt   = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words_q.size() == 0) begin
                    $error("output word 0x%0h arrived with no byte waiting for it",
                           m_axis_tdata);
                    fail_cnt++;
                end else begin
                    exp_word = expected_words_q.pop_front();
                    check_field("byte_kind", 16'(exp_word.byte_kind), 16'(m_axis_tuser[1:0]));
                    check_field("out_byte", 16'(exp_word.out_byte), 16'(m_axis_tdata[7:0]));
                    check_field("entry_data_len", exp_word.body_len, m_axis_tdata[23:8]);
                    check_field("entry_content_type", exp_word.rec_type,
                                m_axis_tdata[39:24]);
                    check_field("entry_path_len", 16'(exp_word.name_len),
                                16'(m_axis_tdata[47:40]));
                    check_field("entry_done", 16'(exp_word.entry_done), 16'(m_axis_tlast));
                    check_field("truncated", 16'(exp_word.truncated), 16'(m_axis_tuser[2]));
                end
                words_cnt++;
                if (m_axis_tlast) begin
                    entries_cnt++;
                end
                if (m_axis_tuser[2]) begin
                    trunc_cnt++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_entry_byte(s_axis_tdata, s_axis_tlast, new_word);
                expected_words_q.push_back(new_word);
            end
        end
        o_fail_count    <= fail_cnt;
        o_pending       <= expected_words_q.size();
        o_words_checked <= words_cnt;
        o_entries_done  <= entries_cnt;
        o_truncations   <= trunc_cnt;
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Stimulus and verdict for the entry record deframer.
// ============================================================================
// Sends blocks of entries: a few hand-built ones for the corner cases, then
// random blocks of well-formed entries, some cut short and some pure noise.
// The run goes through three idle profiles on the two streams, a long output
// hold-off and drains between profiles. All checking is done by erd_checker.
module testbench;
    import erd_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PROFILE_WORDS = 540;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] in_byte
    logic                   s_axis_tlast;   // block_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] out_byte, [23:8] entry_data_len, [39:24] entry_content_type,
    // [47:40] entry_path_len
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // [1:0] byte_kind, [2] truncated
    logic                   m_axis_tlast;   // entry_done

    int fail_count;
    int pending;
    int words_checked;
    int entries_done;
    int truncations;

    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_req;
    int         hold_seen;
    int         hold_left;
    int         stall_cycles;
    int         words_sent;
    int         blocks_sent;
    logic [7:0] block_bytes[$];

    entry_record_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    erd_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_entries_done  (entries_done),
        .o_truncations   (truncations)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Ends the run when no word moves on either stream for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and waits until
    // it is taken. The valid stays high afterwards for back-to-back words.
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Sends the first count bytes of the built block, block end on the last.
    task automatic send_block(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(block_bytes[i], i == count - 1);
        end
        block_bytes.delete();
        blocks_sent++;
    endtask

    // Appends one entry with random path and data bytes; at most max_data
    // data bytes are added, so a large length can be left unfinished.
    task automatic append_entry(input logic [15:0] dlen, input logic [15:0] ctype,
                                input logic [7:0] plen, input int max_data);
        int n_data;
        n_data = (dlen < max_data) ? int'(dlen) : max_data;
        block_bytes.push_back(dlen[15:8]);
        block_bytes.push_back(dlen[7:0]);
        block_bytes.push_back(ctype[15:8]);
        block_bytes.push_back(ctype[7:0]);
        block_bytes.push_back(plen);
        for (int i = 0; i < int'(plen) + n_data; i++) begin
            block_bytes.push_back(8'($urandom));
        end
    endtask

    // Builds and sends one random block: mostly well-formed entries, some cut
    // short, some ending inside a huge data part, and a little noise.
    task automatic random_block();
        int          n_entries;
        int          cut;
        int          r;
        logic [7:0]  plen;
        logic [15:0] dlen;
        if ($urandom_range(99) < 8) begin
            r = $urandom_range(1, 8);
            for (int i = 0; i < r; i++) begin
                block_bytes.push_back(8'($urandom));
            end
            send_block(block_bytes.size());
            return;
        end
        n_entries = $urandom_range(1, 4);
        for (int e = 0; e < n_entries; e++) begin
            r = $urandom_range(99);
            plen = (r < 2) ? 8'hFF : (r < 35) ? 8'h00 : 8'($urandom_range(1, 8));
            r = $urandom_range(99);
            if (r < 4) begin
                // Large data length: the block ends well before the data does.
                append_entry(16'($urandom_range(256, 65535)), 16'($urandom),
                             8'($urandom_range(0, 3)), $urandom_range(0, 6));
                send_block(block_bytes.size());
                return;
            end
            dlen = (r < 30) ? 16'h0000 :
                   (r < 40) ? 16'($urandom_range(9, 40)) : 16'($urandom_range(1, 8));
            append_entry(dlen, 16'($urandom), plen, int'(dlen));
        end
        cut = block_bytes.size();
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(1, cut - 1);
        end
        send_block(cut);
    endtask

    // Stops offering and waits until every expected word has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One idle profile of random blocks, optionally with a long hold-off
    // on the output side halfway through.
    task automatic run_profile(input int send_pct, input int recv_pct, input bit with_hold);
        int stop_at;
        bit hold_done;
        hold_done     = 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        stop_at       = words_sent + PROFILE_WORDS;
        while (words_sent < stop_at) begin
            random_block();
            if (with_hold && !hold_done && words_sent > stop_at - PROFILE_WORDS / 2) begin
                hold_req  <= hold_req + 1;
                hold_done = 1'b1;
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req      <= 0;
        words_sent    = 0;
        blocks_sent   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty entry, then a one-byte path and data with all-ones content
        // type, the block ending on the entry's final byte.
        block_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 8'h01, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'h00};
        send_block(block_bytes.size());
        // Largest data length, block ends inside the data part.
        block_bytes = '{8'hFF, 8'hFF, 8'h12, 8'h34, 8'h00, 8'hAA};
        send_block(block_bytes.size());
        // Block ends on the first header byte.
        block_bytes = '{8'h80};
        send_block(block_bytes.size());
        // Block ends inside the path part.
        block_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h11};
        send_block(block_bytes.size());
        drain();

        run_profile(6, 76, 1'b0);
        run_profile(76, 6, 1'b0);
        run_profile(0, 0, 1'b1);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d blocks under three idle profiles and a long hold-off.",
                 words_sent, blocks_sent);
        $display("Checked %0d words: %0d entries completed, %0d blocks cut short.",
                 words_checked, entries_done, truncations);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/erd_pkg.sv
sv/erd_in_stage.sv
sv/erd_parser.sv
sv/erd_out_stage.sv
sv/entry_record_deframer.sv
test/erd_checker.sv
test/testbench.sv
